>>> hdl/swrl_pkg.sv
// Shared types and constants for the sliding-window rate limiter.
// No dependencies; used by swrl_cell and sliding_window_rate_limiter.
package swrl_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned CFG_A_W = 2;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_MIN_GAP    = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_WINDOW_LEN = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_MAX_PER_WIN = 2'd2;

  localparam logic [STAMP_W-1:0] MIN_GAP_RESET    = 32'd2000;
  localparam logic [STAMP_W-1:0] WINDOW_LEN_RESET = 32'd60000;
  localparam logic [CAP_W-1:0]   MAX_PER_WIN_RESET = 5'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_PUSH
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

>>> hdl/sliding_window_rate_limiter.sv
// Top level of the sliding-window rate limiter: config registers, scan sequencer
// and a row of swrl_cell stamps. Depends on swrl_pkg and swrl_cell.
//
//  port group         dir   beat
//  start/func/now_ms  in    taken when start is high and busy is low
//  cfg_we/index/data  in    taken at any edge with cfg_we high
//  done/allowed/...   out   one cycle with done high; cannot be held off
//
// After an item is accepted, the stamp row rotates once around, one entry past
// the head cell per cycle, then the finish state evaluates and, on a record,
// pushes the new stamp in. busy is high meanwhile.
// Reset is synchronous: it restores the registers and empties the history;
// the stamp cells themselves are not cleared, the fill count masks them.
module sliding_window_rate_limiter #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                func,
  input  logic [swrl_pkg::STAMP_W-1:0]        now_ms,
  output logic                                busy,
  input  logic                                cfg_we,
  input  logic [swrl_pkg::CFG_A_W-1:0]        cfg_index,
  input  logic [swrl_pkg::STAMP_W-1:0]        cfg_data,
  output logic                                done,
  output logic                                allowed,
  output logic [swrl_pkg::CAP_W-1:0]          used_in_window,
  output logic [swrl_pkg::STAMP_W-1:0]        wait_ms
);

  localparam int unsigned STEP_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW     = swrl_pkg::STAMP_W;
  localparam int unsigned CW     = swrl_pkg::CAP_W;

  // configuration
  logic [SW-1:0] min_gap;
  logic [SW-1:0] window_len;
  logic [CW-1:0] win_cap;
  logic [CW-1:0] cap_wr;
  logic [CW-1:0] cap_rst;

  assign cap_wr  = (32'(cfg_data[CW-1:0]) > 32'(HISTORY_DEPTH)) ?
                   CW'(HISTORY_DEPTH) : cfg_data[CW-1:0];
  assign cap_rst = (32'(swrl_pkg::MAX_PER_WIN_RESET) > 32'(HISTORY_DEPTH)) ?
                   CW'(HISTORY_DEPTH) : swrl_pkg::MAX_PER_WIN_RESET;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap    <= swrl_pkg::MIN_GAP_RESET;
      window_len <= swrl_pkg::WINDOW_LEN_RESET;
      win_cap    <= cap_rst;
    end else if (cfg_we) begin
      case (cfg_index)
        swrl_pkg::REG_MIN_GAP:     min_gap    <= cfg_data;
        swrl_pkg::REG_WINDOW_LEN:  window_len <= cfg_data;
        swrl_pkg::REG_MAX_PER_WIN: win_cap    <= cap_wr;
        default: ;
      endcase
    end
  end

  // sequencer
  swrl_pkg::state_t   state, state_next;
  swrl_pkg::cell_op_t cell_op;
  logic [STEP_W-1:0]  step;
  logic               last_step;
  logic               accept;

  assign accept    = start && (state == swrl_pkg::ST_IDLE);
  assign last_step = (step == STEP_W'(HISTORY_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swrl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic req_func;

  always_comb begin
    state_next = state;
    cell_op    = swrl_pkg::CELL_HOLD;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      swrl_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = swrl_pkg::ST_SCAN;
        end
      end
      swrl_pkg::ST_SCAN: begin
        cell_op = swrl_pkg::CELL_ROTATE;
        if (last_step) begin
          state_next = swrl_pkg::ST_FIN;
        end
      end
      swrl_pkg::ST_FIN: begin
        done       = 1'b1;
        state_next = swrl_pkg::ST_IDLE;
        if (req_func) begin
          cell_op = swrl_pkg::CELL_PUSH;
        end
      end
      default: state_next = swrl_pkg::ST_IDLE;
    endcase
  end

  // stamp row: cell 0 holds the newest entry
  logic [SW-1:0] req_now;
  logic [SW-1:0] stamps [HISTORY_DEPTH];

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    swrl_cell u_cell (
      .clk        (clk),
      .op         (cell_op),
      .from_left  ((i == 0) ? req_now : stamps[(i == 0) ? 0 : i - 1]),
      .from_right (stamps[(i + 1) % HISTORY_DEPTH]),
      .stamp      (stamps[i])
    );
  end

  // scan evaluation, one entry per cycle at the head cell
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] used;
  logic             counting;
  logic             gap_block;
  logic [SW-1:0]    gap_wait;
  logic [SW-1:0]    win_wait;
  logic [SW-1:0]    age;
  logic             in_fill;
  logic             in_window;
  logic             at_cap;

  assign age       = req_now - stamps[0];
  assign in_fill   = 32'(step) < 32'(fill_count);
  assign in_window = age < window_len;
  assign at_cap    = (win_cap != '0) &&
                     (32'(step) + 32'd1 == 32'(win_cap));

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func <= func;
      req_now  <= now_ms;
      step     <= '0;
      used     <= '0;
      counting <= (window_len != '0);
      win_wait <= '0;
    end else if (state == swrl_pkg::ST_SCAN) begin
      step <= step + STEP_W'(1);
      if (counting && in_fill && in_window) begin
        used <= used + CNT_W'(1);
      end else begin
        counting <= 1'b0;
      end
      if (step == '0) begin
        gap_block <= (min_gap != '0) && (fill_count != '0) && (age < min_gap);
        gap_wait  <= ((min_gap != '0) && (fill_count != '0) && (age < min_gap)) ?
                     min_gap - age : '0;
      end
      if (at_cap) begin
        win_wait <= (in_fill && in_window) ? window_len - age : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (state == swrl_pkg::ST_FIN && req_func &&
                 32'(fill_count) < 32'(HISTORY_DEPTH)) begin
      fill_count <= fill_count + CNT_W'(1);
    end
  end

  // result
  logic             win_block;
  logic             muted;
  logic [CNT_W+CW-1:0] used_wide;

  assign muted     = (win_cap == '0);
  assign win_block = (window_len != '0) && !muted &&
                     (32'(used) >= 32'(win_cap));
  assign allowed   = !muted && !gap_block && !win_block;
  assign used_wide = {{CW{1'b0}}, used};
  assign used_in_window = used_wide[CW-1:0];

  // the window wait only counts when the window check blocks
  always_comb begin
    if (muted) begin
      wait_ms = '1;
    end else if (allowed) begin
      wait_ms = '0;
    end else begin
      wait_ms = (win_block && (win_wait > gap_wait)) ? win_wait : gap_wait;
    end
  end

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy still high after done");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) <= 32'(HISTORY_DEPTH))
    else $error("fill count beyond history depth");

  a_allowed_wait: assert property (@(posedge clk) disable iff (rst)
    (done && allowed) |-> (wait_ms == '0))
    else $error("allowed result carries a wait");

  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    (state == swrl_pkg::ST_SCAN && last_step) |=> done)
    else $error("scan did not end in a result");

endmodule

>>> hdl/swrl_cell.sv
// One history cell: holds a single event stamp.
// Depends on swrl_pkg for the cell operation type.
module swrl_cell (
  input  logic                          clk,
  input  swrl_pkg::cell_op_t            op,
  input  logic [swrl_pkg::STAMP_W-1:0]  from_left,
  input  logic [swrl_pkg::STAMP_W-1:0]  from_right,
  output logic [swrl_pkg::STAMP_W-1:0]  stamp
);

  logic [swrl_pkg::STAMP_W-1:0] stamp_next;

  always_comb begin
    case (op)
      swrl_pkg::CELL_ROTATE: stamp_next = from_right; // advance toward the head
      swrl_pkg::CELL_PUSH:   stamp_next = from_left;  // age by one slot
      default:               stamp_next = stamp;
    endcase
  end

  always_ff @(posedge clk) begin
    stamp <= stamp_next;
  end

endmodule

>>> sim/sliding_window_rate_limiter_tb.sv
// Self-checking testbench for sliding_window_rate_limiter: directed and random
// query/record beats, each result checked against an in-bench budget predictor.
// Depends on swrl_pkg and the RTL under hdl/.
module sliding_window_rate_limiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int LIMIT_CYCLES = 1000000;
  localparam int TAIL_CYCLES = 2 * (DEPTH + 1) + 8;
  localparam int MAX_REPORTS = 20;
  // index with no register behind it; writes must be dropped
  localparam logic [swrl_pkg::CFG_A_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic {
    FN_QUERY  = 1'b0,
    FN_RECORD = 1'b1
  } fn_t;

  typedef struct packed {
    logic                         allowed;
    logic [swrl_pkg::CAP_W-1:0]   used;
    logic [swrl_pkg::STAMP_W-1:0] wait_ms;
  } verdict_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         func = 1'b0;
  logic [swrl_pkg::STAMP_W-1:0] now_ms = '0;
  logic                         busy;
  logic                         cfg_we = 1'b0;
  logic [swrl_pkg::CFG_A_W-1:0] cfg_index = '0;
  logic [swrl_pkg::STAMP_W-1:0] cfg_data = '0;
  logic                         done;
  logic                         allowed;
  logic [swrl_pkg::CAP_W-1:0]   used_in_window;
  logic [swrl_pkg::STAMP_W-1:0] wait_ms;

  // predictor copy of registers and history
  logic [swrl_pkg::STAMP_W-1:0] gap_ms;
  logic [swrl_pkg::STAMP_W-1:0] win_ms;
  logic [swrl_pkg::CAP_W-1:0]   cap;
  logic [swrl_pkg::STAMP_W-1:0] stamp_hist [DEPTH];
  logic [PTR_W-1:0]             next_slot;
  logic [swrl_pkg::CAP_W-1:0]   stamp_cnt;

  verdict_t                     verdict_q [$];
  verdict_t                     want_v;
  logic [swrl_pkg::STAMP_W-1:0] clock_ms = '0;
  int                           n_items = 0;
  int                           n_records = 0;
  int                           n_checked = 0;
  int                           n_cfg = 0;
  int                           n_errors = 0;
  int                           n_cycles = 0;

  sliding_window_rate_limiter #(
    .HISTORY_DEPTH(DEPTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .func          (func),
    .now_ms        (now_ms),
    .busy          (busy),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .allowed       (allowed),
    .used_in_window(used_in_window),
    .wait_ms       (wait_ms)
  );

  always #6 clk = ~clk;

  function automatic void clear_history();
    gap_ms = swrl_pkg::MIN_GAP_RESET;
    win_ms = swrl_pkg::WINDOW_LEN_RESET;
    cap = swrl_pkg::MAX_PER_WIN_RESET;
    foreach (stamp_hist[i]) stamp_hist[i] = '0;
    next_slot = '0;
    stamp_cnt = '0;
  endfunction

  function automatic void apply_reg(input logic [swrl_pkg::CFG_A_W-1:0] idx,
                                    input logic [swrl_pkg::STAMP_W-1:0] data);
    case (idx)
      swrl_pkg::REG_MIN_GAP: gap_ms = data;
      swrl_pkg::REG_WINDOW_LEN: win_ms = data;
      swrl_pkg::REG_MAX_PER_WIN: begin
        // only the low bits count, then clamp to the history depth
        cap = (data[swrl_pkg::CAP_W-1:0] > DEPTH) ?
              swrl_pkg::CAP_W'(DEPTH) : data[swrl_pkg::CAP_W-1:0];
      end
      default: ;
    endcase
  endfunction

  // n = 0 is the newest stamp
  function automatic logic [swrl_pkg::STAMP_W-1:0] stamp_back(input int n);
    logic [PTR_W-1:0] slot;
    slot = next_slot - 1'b1 - n[PTR_W-1:0];
    return stamp_hist[slot];
  endfunction

  function automatic verdict_t predict_verdict(input logic [swrl_pkg::STAMP_W-1:0] t);
    verdict_t                     v;
    logic [swrl_pkg::CAP_W-1:0]   used;
    logic [swrl_pkg::STAMP_W-1:0] since;
    logic [swrl_pkg::STAMP_W-1:0] age;
    logic [swrl_pkg::STAMP_W-1:0] gap_wait;
    logic [swrl_pkg::STAMP_W-1:0] win_wait;
    logic                         gap_block;
    logic                         win_block;
    logic                         counting;
    used = '0;
    gap_wait = '0;
    win_wait = '0;
    gap_block = 1'b0;
    win_block = 1'b0;
    counting = (win_ms != 0);
    // count newest first, stop at the first stamp outside the window or the fill
    for (int n = 0; n < DEPTH; n++) begin
      age = t - stamp_back(n);
      if (counting && n < stamp_cnt && age < win_ms) used++;
      else counting = 1'b0;
    end
    if (gap_ms != 0 && stamp_cnt != 0) begin
      since = t - stamp_back(0);
      if (since < gap_ms) begin
        gap_block = 1'b1;
        gap_wait = gap_ms - since;
      end
    end
    if (win_ms != 0 && cap != 0 && used >= cap) begin
      win_block = 1'b1;
      age = t - stamp_back(cap - 1);
      win_wait = (age < win_ms) ? win_ms - age : '0;
    end
    v.used = used;
    if (cap == 0) begin
      v.allowed = 1'b0;
      v.wait_ms = '1;
    end else if (!gap_block && !win_block) begin
      v.allowed = 1'b1;
      v.wait_ms = '0;
    end else begin
      v.allowed = 1'b0;
      v.wait_ms = (win_wait > gap_wait) ? win_wait : gap_wait;
    end
    return v;
  endfunction

  function automatic void log_stamp(input logic [swrl_pkg::STAMP_W-1:0] t);
    stamp_hist[next_slot] = t;
    next_slot++;
    if (stamp_cnt < DEPTH) stamp_cnt++;
  endfunction

  // next timestamp, mostly stepped on the scale of the current gap and window
  function automatic logic [swrl_pkg::STAMP_W-1:0] next_time(
      input logic [swrl_pkg::STAMP_W-1:0] t);
    logic [swrl_pkg::STAMP_W-1:0] g;
    logic [swrl_pkg::STAMP_W-1:0] w;
    int                           pick;
    g = (gap_ms > 100000) ? 100000 : gap_ms;
    w = (win_ms > 1000000) ? 1000000 : win_ms;
    pick = $urandom_range(0, 99);
    if (pick < 10) return t;
    if (pick < 40) return t + $urandom_range(0, g + 2);
    if (pick < 70) return t + $urandom_range(0, w / (cap + 1) + 2);
    if (pick < 80) return t + win_ms + $urandom_range(0, 4) - 2;
    if (pick < 90) return t + gap_ms + $urandom_range(0, 2) - 1;
    if (pick < 95) return t - $urandom_range(1, 1000);
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [swrl_pkg::STAMP_W-1:0] got,
                                 input logic [swrl_pkg::STAMP_W-1:0] want);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // hold the beat until the block takes it, then predict from pre-beat state
  task automatic send_beat(input fn_t fn, input logic [swrl_pkg::STAMP_W-1:0] t);
    @(negedge clk);
    start = 1'b1;
    func = fn;
    now_ms = t;
    @(posedge clk);
    while (busy) @(posedge clk);
    verdict_q.push_back(predict_verdict(t));
    if (fn == FN_RECORD) begin
      log_stamp(t);
      n_records++;
    end
    n_items++;
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // drop start and wait for every pending result
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (verdict_q.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [swrl_pkg::CFG_A_W-1:0] idx,
                           input logic [swrl_pkg::STAMP_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    apply_reg(idx, data);
    n_cfg++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_phase(input int n, input int idle_pct);
    fn_t fn;
    for (int i = 0; i < n; i++) begin
      clock_ms = next_time(clock_ms);
      fn = ($urandom_range(0, 99) < 55) ? FN_RECORD : FN_QUERY;
      send_beat(fn, clock_ms);
      if ($urandom_range(0, 99) < idle_pct) pause($urandom_range(1, 24));
    end
    settle();
  endtask

  // reset values: gap block, window block, oldest stamp ageing out
  task automatic test_reset_values();
    send_beat(FN_QUERY, 32'd0);
    send_beat(FN_RECORD, 32'd0);
    send_beat(FN_QUERY, 32'd1000);
    send_beat(FN_RECORD, 32'd2000);
    send_beat(FN_RECORD, 32'd4000);
    send_beat(FN_RECORD, 32'd6000);
    send_beat(FN_QUERY, 32'd8000);
    send_beat(FN_QUERY, 32'd60000);
    send_beat(FN_RECORD, 32'd60001);
    settle();
  endtask

  // mute, clamp, disabled checks, unused index and all-ones registers
  task automatic test_config_corners();
    write_reg(REG_SPARE, 32'h0000_0001);
    write_reg(swrl_pkg::REG_MAX_PER_WIN, '0);
    send_beat(FN_QUERY, 32'd60002);
    settle();
    write_reg(swrl_pkg::REG_MAX_PER_WIN, 32'hFFFF_FFFF);
    write_reg(swrl_pkg::REG_WINDOW_LEN, '0);
    send_beat(FN_QUERY, 32'd60003);
    settle();
    write_reg(swrl_pkg::REG_MIN_GAP, '0);
    send_beat(FN_QUERY, 32'd60004);
    settle();
    write_reg(swrl_pkg::REG_MIN_GAP, 32'hFFFF_FFFF);
    write_reg(swrl_pkg::REG_WINDOW_LEN, 32'hFFFF_FFFF);
    send_beat(FN_QUERY, 32'd60005);
    send_beat(FN_RECORD, 32'd60005);
    send_beat(FN_QUERY, 32'd60005);
    settle();
  endtask

  // differences across the 2^32 wrap, and time running backwards
  task automatic test_time_wrap();
    write_reg(swrl_pkg::REG_MIN_GAP, 32'd2000);
    write_reg(swrl_pkg::REG_WINDOW_LEN, 32'd60000);
    write_reg(swrl_pkg::REG_MAX_PER_WIN, 32'd2);
    send_beat(FN_RECORD, 32'hFFFF_FC00);
    send_beat(FN_QUERY, 32'h0000_0100);
    send_beat(FN_RECORD, 32'h0000_0800);
    send_beat(FN_QUERY, 32'h0000_1000);
    send_beat(FN_RECORD, 32'hFFFF_FFFF);
    send_beat(FN_QUERY, 32'h0000_0000);
    settle();
  endtask

  task automatic test_random();
    clock_ms = 32'hFFFF_F000;
    write_reg(swrl_pkg::REG_MIN_GAP, 32'd50);
    write_reg(swrl_pkg::REG_WINDOW_LEN, 32'd400);
    write_reg(swrl_pkg::REG_MAX_PER_WIN, 32'd3);
    random_phase(300, 0);
    write_reg(swrl_pkg::REG_MIN_GAP, '0);
    write_reg(swrl_pkg::REG_WINDOW_LEN, 32'd1000);
    write_reg(swrl_pkg::REG_MAX_PER_WIN, 32'd16);
    random_phase(300, 60);
    write_reg(swrl_pkg::REG_MIN_GAP, 32'd200);
    write_reg(swrl_pkg::REG_WINDOW_LEN, '0);
    write_reg(swrl_pkg::REG_MAX_PER_WIN, 32'd5);
    random_phase(200, 18);
    write_reg(swrl_pkg::REG_MIN_GAP, 32'd30);
    write_reg(swrl_pkg::REG_WINDOW_LEN, 32'd250);
    write_reg(swrl_pkg::REG_MAX_PER_WIN, 32'd1);
    random_phase(250, 0);
    write_reg(swrl_pkg::REG_MIN_GAP, $urandom_range(0, 500));
    write_reg(swrl_pkg::REG_WINDOW_LEN, $urandom_range(0, 5000));
    write_reg(swrl_pkg::REG_MAX_PER_WIN, $urandom);
    random_phase(300, 60);
    write_reg(swrl_pkg::REG_MIN_GAP, 32'd100);
    write_reg(swrl_pkg::REG_WINDOW_LEN, 32'd500);
    write_reg(swrl_pkg::REG_MAX_PER_WIN, '0);
    random_phase(150, 18);
    write_reg(swrl_pkg::REG_MIN_GAP, 32'hFFFF_FFFF);
    write_reg(swrl_pkg::REG_WINDOW_LEN, 32'hFFFF_FFFF);
    write_reg(swrl_pkg::REG_MAX_PER_WIN, 32'd16);
    random_phase(150, 0);
    write_reg(REG_SPARE, $urandom);
    write_reg(swrl_pkg::REG_MIN_GAP, $urandom_range(0, 3000));
    write_reg(swrl_pkg::REG_WINDOW_LEN, $urandom_range(0, 20000));
    write_reg(swrl_pkg::REG_MAX_PER_WIN, $urandom_range(0, 31));
    random_phase(300, 60);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result with none pending", '0, '0);
      end else begin
        want_v = verdict_q.pop_front();
        n_checked++;
        if (allowed !== want_v.allowed)
          report_mismatch("allowed", allowed, want_v.allowed);
        if (used_in_window !== want_v.used)
          report_mismatch("used_in_window", used_in_window, want_v.used);
        if (wait_ms !== want_v.wait_ms)
          report_mismatch("wait_ms", wait_ms, want_v.wait_ms);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", n_cycles, verdict_q.size());
      $display("sliding_window_rate_limiter_tb NOT OK");
      $finish;
    end
  end

  initial begin
    clear_history();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_values();
    test_config_corners();
    test_time_wrap();
    test_random();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) report_mismatch("results never arrived", verdict_q.size(), '0);
    $display("%0d beats (%0d records), %0d results checked, %0d register writes;",
             n_items, n_records, n_checked, n_cfg);
    $display("covered mute, clamped cap, disabled gap and window, wrapped time, idle gaps");
    if (n_errors == 0) begin
      $display("sliding_window_rate_limiter_tb OK");
    end else begin
      $display("sliding_window_rate_limiter_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/swrl_pkg.sv
hdl/swrl_cell.sv
hdl/sliding_window_rate_limiter.sv
sim/sliding_window_rate_limiter_tb.sv
